/* rtl/csot_pkg.sv */
// Package with shared constants and the arctangent table for the cone overlap test.
`default_nettype none
package csot_pkg;

	// Angle formats: results in 1/64 degree, accumulator in 2^-14 degree.
	localparam int ZW          = 24;
	localparam int ANGW        = 16;
	localparam int APW         = 15;
	localparam int DIFFW       = 17;
	localparam int ZFRAC_SHIFT = 8;

	localparam logic signed [ZW-1:0]    QUARTER_TURN_Z = 24'sd1474560;
	localparam logic signed [ZW-1:0]    ROUND_HALF_Z   = 24'sd128;
	localparam logic signed [DIFFW-1:0] HALF_TURN_64   = 17'sd11520;
	localparam logic signed [DIFFW-1:0] FULL_TURN_64   = 17'sd23040;

	// atan(2^-i) in 2^-14 degree, rounded to nearest.
	localparam int ATAN_LEN = 24;
	localparam logic [ZW-1:0] ATAN_STEPS [0:ATAN_LEN-1] = '{
		24'd737280, 24'd435242, 24'd229970, 24'd116736, 24'd58595, 24'd29326,
		24'd14667,  24'd7334,   24'd3667,   24'd1833,   24'd917,   24'd458,
		24'd229,    24'd115,    24'd57,     24'd29,     24'd14,    24'd7,
		24'd4,      24'd2,      24'd1,      24'd0,      24'd0,     24'd0
	};

endpackage
`default_nettype wire

/* rtl/csot_front.sv */
// Front stages: offsets, squares and CORDIC pre-rotation of one query.
`default_nettype none
module csot_front #(
	parameter int CW = 24
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic                   func,
	input  wire logic signed [CW-1:0]   cone_x,
	input  wire logic signed [CW-1:0]   cone_y,
	input  wire logic        [CW-2:0]   cone_reach,
	input  wire logic [csot_pkg::APW-1:0]        cone_aperture,
	input  wire logic signed [csot_pkg::ANGW-1:0] cone_heading,
	input  wire logic signed [CW-1:0]   target_x,
	input  wire logic signed [CW-1:0]   target_y,
	input  wire logic        [CW-2:0]   target_radius,
	input  wire logic        [CW-2:0]   rect_width,
	input  wire logic        [CW-2:0]   rect_height,
	output logic                        rect_s2,
	output logic                        zero_s2,
	output logic [2*(CW+2)-1:0]         dxsq_s2,
	output logic [2*(CW+2)-1:0]         dysq_s2,
	output logic [2*CW-1:0]             rad_s2,
	output logic signed [CW+4:0]        x_s2,
	output logic signed [CW+4:0]        y_s2,
	output logic signed [csot_pkg::ZW-1:0] z_s2,
	output logic [CW-2:0]               reach_s2,
	output logic [CW-2:0]               tr_s2,
	output logic [csot_pkg::APW-1:0]    ap_s2,
	output logic signed [csot_pkg::ANGW-1:0] hd_s2
);

	localparam int LW = CW - 1;
	localparam int DW = CW + 3;
	localparam int MW = CW + 2;
	localparam int XW = CW + 5;

	logic signed [DW-1:0] ax, ay, tx, ty, dx, dy;
	logic [DW-1:0]        wadd, hadd;

	logic                 rect_s1;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic [2*LW-1:0]      wsq_s1, hsq_s1;
	logic [LW-1:0]        reach_s1, tr_s1;
	logic [csot_pkg::APW-1:0]         ap_s1;
	logic signed [csot_pkg::ANGW-1:0] hd_s1;

	logic [MW-1:0]        dxm, dym;
	logic signed [XW-1:0] dxe, dye;

	// Positions in half-LSB units; a rectangle moves to its center.
	always_comb begin
		ax   = {{2{cone_x[CW-1]}}, cone_x, 1'b0};
		ay   = {{2{cone_y[CW-1]}}, cone_y, 1'b0};
		wadd = func ? {4'b0, rect_width} : '0;
		hadd = func ? {4'b0, rect_height} : '0;
		tx   = {{2{target_x[CW-1]}}, target_x, 1'b0} + signed'(wadd);
		ty   = {{2{target_y[CW-1]}}, target_y, 1'b0} + signed'(hadd);
		dx   = tx - ax;
		dy   = ty - ay;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rect_s1  <= func;
			dx_s1    <= dx;
			dy_s1    <= dy;
			wsq_s1   <= rect_width * rect_width;
			hsq_s1   <= rect_height * rect_height;
			reach_s1 <= cone_reach;
			tr_s1    <= target_radius;
			ap_s1    <= cone_aperture;
			hd_s1    <= cone_heading;
		end
	end

	// Magnitudes for the distance squares, and sign extension for CORDIC.
	always_comb begin
		dxm = dx_s1[DW-1] ? MW'(-dx_s1) : MW'(dx_s1);
		dym = dy_s1[DW-1] ? MW'(-dy_s1) : MW'(dy_s1);
		dxe = {{2{dx_s1[DW-1]}}, dx_s1};
		dye = {{2{dy_s1[DW-1]}}, dy_s1};
	end

	// Quarter-turn pre-rotation into the right half plane.
	always_ff @(posedge clk) begin
		if (en) begin
			rect_s2  <= rect_s1;
			zero_s2  <= (dx_s1 == '0) && (dy_s1 == '0);
			dxsq_s2  <= dxm * dxm;
			dysq_s2  <= dym * dym;
			rad_s2   <= {1'b0, {1'b0, wsq_s1} + {1'b0, hsq_s1}};
			reach_s2 <= reach_s1;
			tr_s2    <= tr_s1;
			ap_s2    <= ap_s1;
			hd_s2    <= hd_s1;
			if (!dx_s1[DW-1]) begin
				x_s2 <= dxe;
				y_s2 <= dye;
				z_s2 <= '0;
			end else if (!dy_s1[DW-1]) begin
				x_s2 <= dye;
				y_s2 <= -dxe;
				z_s2 <= csot_pkg::QUARTER_TURN_Z;
			end else begin
				x_s2 <= -dye;
				y_s2 <= dxe;
				z_s2 <= -csot_pkg::QUARTER_TURN_Z;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/csot_sqrt_stage.sv */
// One registered digit step of the integer square root.
`default_nettype none
module csot_sqrt_stage #(
	parameter int S = 24,
	parameter int I = 0
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [2*S-1:0] rad,
	input  wire logic [S+1:0] rem,
	input  wire logic [S-1:0] root,
	output logic [2*S-1:0]    rad_q,
	output logic [S+1:0]      rem_q,
	output logic [S-1:0]      root_q
);

	logic [S+3:0] cat, trial;

	// Bring down the next two radicand bits and try a one digit.
	always_comb begin
		cat   = {rem, rad[2*S-1-2*I -: 2]};
		trial = {2'b00, root, 2'b01};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q <= rad;
			if (cat >= trial) begin
				rem_q  <= (S+2)'(cat - trial);
				root_q <= {root[S-2:0], 1'b1};
			end else begin
				rem_q  <= cat[S+1:0];
				root_q <= {root[S-2:0], 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/csot_cordic_stage.sv */
// One registered vectoring CORDIC iteration.
`default_nettype none
module csot_cordic_stage #(
	parameter int XW = 29,
	parameter int I  = 0
) (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic signed [XW-1:0]           x,
	input  wire logic signed [XW-1:0]           y,
	input  wire logic signed [csot_pkg::ZW-1:0] z,
	output logic signed [XW-1:0]                x_q,
	output logic signed [XW-1:0]                y_q,
	output logic signed [csot_pkg::ZW-1:0]      z_q
);

	localparam logic signed [csot_pkg::ZW-1:0] STEP = csot_pkg::ATAN_STEPS[I];

	logic signed [XW-1:0] xs, ys;

	always_comb begin
		xs = x >>> I;
		ys = y >>> I;
	end

	// Rotate toward the x axis and accumulate the angle.
	always_ff @(posedge clk) begin
		if (en) begin
			if (y > 0) begin
				x_q <= x + ys;
				y_q <= y - xs;
				z_q <= z + STEP;
			end else begin
				x_q <= x - ys;
				y_q <= y + xs;
				z_q <= z - STEP;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/csot_finish.sv */
// Final stages: target radius, reach square, bearing wrap and hit decision.
`default_nettype none
module csot_finish #(
	parameter int CW = 24
) (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic                           rect,
	input  wire logic                           zero,
	input  wire logic [2*(CW+2):0]              dsq,
	input  wire logic [CW-1:0]                  root,
	input  wire logic [CW-2:0]                  reach,
	input  wire logic [CW-2:0]                  tr,
	input  wire logic [csot_pkg::APW-1:0]       ap,
	input  wire logic signed [csot_pkg::ANGW-1:0] hd,
	input  wire logic signed [csot_pkg::ZW-1:0] z,
	output logic                                hit_s2
);

	localparam int QW  = 2 * (CW + 2) + 1;
	localparam int SW  = CW + 1;
	localparam int DFW = csot_pkg::DIFFW;

	logic [CW-1:0]                  trad;
	logic [SW-1:0]                  sum;
	logic signed [csot_pkg::ZW-1:0] zr;
	logic signed [DFW-1:0]          brg, diff, d1, d2, dmag;
	logic [DFW:0]                   twice;

	logic [2*SW-1:0] sumsq_s1;
	logic [QW-1:0]   dsq_s1;
	logic            angok_s1;

	// Target radius in half-LSB units and the summed reach.
	always_comb begin
		trad = rect ? root : {tr, 1'b0};
		sum  = {1'b0, reach, 1'b0} + {1'b0, trad};
	end

	// Round the bearing to 1/64 degree, subtract heading, wrap twice at most.
	always_comb begin
		zr    = z + csot_pkg::ROUND_HALF_Z;
		brg   = zero ? '0 : DFW'(zr >>> csot_pkg::ZFRAC_SHIFT);
		diff  = brg - {hd[csot_pkg::ANGW-1], hd};
		if (diff > csot_pkg::HALF_TURN_64) begin
			d1 = diff - csot_pkg::FULL_TURN_64;
		end else if (diff < -csot_pkg::HALF_TURN_64) begin
			d1 = diff + csot_pkg::FULL_TURN_64;
		end else begin
			d1 = diff;
		end
		if (d1 > csot_pkg::HALF_TURN_64) begin
			d2 = d1 - csot_pkg::FULL_TURN_64;
		end else if (d1 < -csot_pkg::HALF_TURN_64) begin
			d2 = d1 + csot_pkg::FULL_TURN_64;
		end else begin
			d2 = d1;
		end
		dmag  = d2[DFW-1] ? -d2 : d2;
		twice = {dmag, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sumsq_s1 <= sum * sum;
			dsq_s1   <= dsq;
			angok_s1 <= twice <= {{(DFW+1-csot_pkg::APW){1'b0}}, ap};
		end
	end

	// Equality of distance and reach still counts as a hit.
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s2 <= angok_s1 && (dsq_s1 <= {{(QW-2*SW){1'b0}}, sumsq_s1});
		end
	end

endmodule
`default_nettype wire

/* rtl/cone_sector_overlap_test.sv */
// Top level of the cone against circle or rectangle overlap test.
//  channel | valid        | stall        | payload
//  query   | item_valid   | item_stall   | func, cone_*, target_*, rect_*
//  result  | result_valid | result_stall | hit
// One query enters per cycle while the pipeline is not stalled; the unrolled root digit
// and CORDIC stages run side by side.
// Reset clears only the valid bits of the pipeline.
// A stalled result freezes the whole pipeline, and item_stall rises in the same cycle.
`default_nettype none
module cone_sector_overlap_test #(
	parameter int COORD_WIDTH      = 24,
	parameter int ANGLE_ITERATIONS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire logic                             func,
	input  wire logic signed [COORD_WIDTH-1:0]    cone_x,
	input  wire logic signed [COORD_WIDTH-1:0]    cone_y,
	input  wire logic        [COORD_WIDTH-2:0]    cone_reach,
	input  wire logic [csot_pkg::APW-1:0]         cone_aperture,
	input  wire logic signed [csot_pkg::ANGW-1:0] cone_heading,
	input  wire logic signed [COORD_WIDTH-1:0]    target_x,
	input  wire logic signed [COORD_WIDTH-1:0]    target_y,
	input  wire logic        [COORD_WIDTH-2:0]    target_radius,
	input  wire logic        [COORD_WIDTH-2:0]    rect_width,
	input  wire logic        [COORD_WIDTH-2:0]    rect_height,
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output logic                                  hit
);

	localparam int CW  = COORD_WIDTH;
	localparam int N   = ANGLE_ITERATIONS;
	localparam int S   = CW;
	localparam int L   = (S > N) ? S : N;
	localparam int LW  = CW - 1;
	localparam int MW  = CW + 2;
	localparam int QW  = 2 * MW + 1;
	localparam int XW  = CW + 5;
	localparam int ZW  = csot_pkg::ZW;
	localparam int LAT = L + 4;

	typedef struct packed {
		logic                             rect;
		logic                             zero;
		logic [QW-1:0]                    dsq;
		logic [LW-1:0]                    reach;
		logic [LW-1:0]                    tr;
		logic [csot_pkg::APW-1:0]         ap;
		logic signed [csot_pkg::ANGW-1:0] hd;
	} side_t;

	logic en;
	logic [LAT-1:0] vld_q;

	logic                 rect_f, zero_f;
	logic [2*MW-1:0]      dxsq_f, dysq_f;
	logic [2*S-1:0]       rad_f;
	logic [LW-1:0]        reach_f, tr_f;
	logic [csot_pkg::APW-1:0]         ap_f;
	logic signed [csot_pkg::ANGW-1:0] hd_f;

	side_t               side_sl [0:L];
	logic [2*S-1:0]      rad_sl  [0:L];
	logic [S+1:0]        rem_sl  [0:L];
	logic [S-1:0]        root_sl [0:L];
	logic signed [XW-1:0] x_sl   [0:L];
	logic signed [XW-1:0] y_sl   [0:L];
	logic signed [ZW-1:0] z_sl   [0:L];

	// The pipeline moves unless a finished result is held.
	assign en           = !(result_valid && result_stall);
	assign item_stall   = !en;
	assign result_valid = vld_q[LAT-1];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], item_valid};
		end
	end

	csot_front #(.CW(CW)) u_front (
		.clk           (clk),
		.en            (en),
		.func          (func),
		.cone_x        (cone_x),
		.cone_y        (cone_y),
		.cone_reach    (cone_reach),
		.cone_aperture (cone_aperture),
		.cone_heading  (cone_heading),
		.target_x      (target_x),
		.target_y      (target_y),
		.target_radius (target_radius),
		.rect_width    (rect_width),
		.rect_height   (rect_height),
		.rect_s2       (rect_f),
		.zero_s2       (zero_f),
		.dxsq_s2       (dxsq_f),
		.dysq_s2       (dysq_f),
		.rad_s2        (rad_f),
		.x_s2          (x_sl[0]),
		.y_s2          (y_sl[0]),
		.z_s2          (z_sl[0]),
		.reach_s2      (reach_f),
		.tr_s2         (tr_f),
		.ap_s2         (ap_f),
		.hd_s2         (hd_f)
	);

	// Entry of the iterative section; the distance sum is formed here.
	always_comb begin
		side_sl[0].rect  = rect_f;
		side_sl[0].zero  = zero_f;
		side_sl[0].dsq   = {1'b0, dxsq_f} + {1'b0, dysq_f};
		side_sl[0].reach = reach_f;
		side_sl[0].tr    = tr_f;
		side_sl[0].ap    = ap_f;
		side_sl[0].hd    = hd_f;
		rad_sl[0]        = rad_f;
		rem_sl[0]        = '0;
		root_sl[0]       = '0;
	end

	// Root digit and CORDIC iteration side by side, one per stage; the shorter chain holds its values.
	for (genvar i = 0; i < L; i++) begin : g_loop
		always_ff @(posedge clk) begin
			if (en) begin
				side_sl[i+1] <= side_sl[i];
			end
		end

		if (i < S) begin : g_sqrt
			csot_sqrt_stage #(.S(S), .I(i)) u_sqrt (
				.clk    (clk),
				.en     (en),
				.rad    (rad_sl[i]),
				.rem    (rem_sl[i]),
				.root   (root_sl[i]),
				.rad_q  (rad_sl[i+1]),
				.rem_q  (rem_sl[i+1]),
				.root_q (root_sl[i+1])
			);
		end else begin : g_sqrt_hold
			always_ff @(posedge clk) begin
				if (en) begin
					rad_sl[i+1]  <= rad_sl[i];
					rem_sl[i+1]  <= rem_sl[i];
					root_sl[i+1] <= root_sl[i];
				end
			end
		end

		if (i < N) begin : g_cordic
			csot_cordic_stage #(.XW(XW), .I(i)) u_cordic (
				.clk (clk),
				.en  (en),
				.x   (x_sl[i]),
				.y   (y_sl[i]),
				.z   (z_sl[i]),
				.x_q (x_sl[i+1]),
				.y_q (y_sl[i+1]),
				.z_q (z_sl[i+1])
			);
		end else begin : g_cordic_hold
			always_ff @(posedge clk) begin
				if (en) begin
					x_sl[i+1] <= x_sl[i];
					y_sl[i+1] <= y_sl[i];
					z_sl[i+1] <= z_sl[i];
				end
			end
		end
	end

	csot_finish #(.CW(CW)) u_finish (
		.clk    (clk),
		.en     (en),
		.rect   (side_sl[L].rect),
		.zero   (side_sl[L].zero),
		.dsq    (side_sl[L].dsq),
		.root   (root_sl[L]),
		.reach  (side_sl[L].reach),
		.tr     (side_sl[L].tr),
		.ap     (side_sl[L].ap),
		.hd     (side_sl[L].hd),
		.z      (z_sl[L]),
		.hit_s2 (hit)
	);

	// A held result freezes the count of queries in flight.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $countones(vld_q) == $past($countones(vld_q)))
		else $error("pipeline occupancy changed while the result was held");

	// An accepted query occupies the first stage in the next cycle.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> vld_q[0])
		else $error("accepted transfer did not enter the pipeline");

	// A free output lets the pipeline advance by one stage.
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!result_stall |=> vld_q[LAT-1:1] == $past(vld_q[LAT-2:0]))
		else $error("pipeline did not advance with a free output");

endmodule
`default_nettype wire
